// ===== src/gnz_pkg.sv =====
// Shared types and constants for the 3-D gradient noise core.
// No dependencies; every other file but gnz_ram imports this package.
`default_nettype none
package gnz_pkg;

    // Number format and table geometry
    localparam int FRAC_BITS  = 16;
    localparam int TABLE_SIZE = 256;
    localparam int TAW        = $clog2(TABLE_SIZE);
    localparam int DATA_W     = 8;
    localparam int COORD_W    = 32;
    localparam int OUT_W      = 18;

    // Fade values reach up to 15 * ONE before the final shift
    localparam int FADE_W = FRAC_BITS + 4;
    // Gradients and lerp results span [-2*ONE, 2*ONE]
    localparam int VAL_W  = FRAC_BITS + 3;

    // Front queue
    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // One classified item as it leaves the front
    typedef struct packed {
        logic                           is_load;
        logic [TAW-1:0]                 waddr;
        logic [DATA_W-1:0]              wdata;
        logic [2:0][TAW-1:0]            lattice;
        logic [2:0][FRAC_BITS-1:0]      frac;
    } t_cmd;

    // Queue head as seen by the back part
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

endpackage
`default_nettype wire

// ===== src/gnz_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none
module gnz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr_b,
    output logic [WIDTH-1:0]                o_rdata_a,
    output logic [WIDTH-1:0]                o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    // write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule
`default_nettype wire

// ===== src/gnz_front.sv =====
// Front part: accepts items, splits coordinates into lattice index and fraction,
// and queues them for the back part. Depends on gnz_pkg.
`default_nettype none
module gnz_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_kind,
    input  wire logic [gnz_pkg::TAW-1:0]            i_table_index,
    input  wire logic [gnz_pkg::DATA_W-1:0]         i_table_value,
    input  wire logic signed [gnz_pkg::COORD_W-1:0] i_x_coord,
    input  wire logic signed [gnz_pkg::COORD_W-1:0] i_y_coord,
    input  wire logic signed [gnz_pkg::COORD_W-1:0] i_z_coord,
    output gnz_pkg::t_qhead                         o_head,
    input  wire logic                               i_pop
);
    import gnz_pkg::*;

    t_cmd           r_q [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    t_cmd           cmd_in;
    logic           push;
    logic           pop;

    // classify the incoming item
    always_comb begin
        cmd_in.is_load    = (i_kind == KIND_LOAD);
        cmd_in.waddr      = i_table_index;
        cmd_in.wdata      = i_table_value;
        cmd_in.lattice[0] = i_x_coord[FRAC_BITS +: TAW];
        cmd_in.lattice[1] = i_y_coord[FRAC_BITS +: TAW];
        cmd_in.lattice[2] = i_z_coord[FRAC_BITS +: TAW];
        cmd_in.frac[0]    = i_x_coord[FRAC_BITS-1:0];
        cmd_in.frac[1]    = i_y_coord[FRAC_BITS-1:0];
        cmd_in.frac[2]    = i_z_coord[FRAC_BITS-1:0];
    end

    assign o_in_stall = (r_cnt == (QAW+1)'(QDEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_pop && (r_cnt != '0);

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (QAW+1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (QAW+1)'(1);
            end
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_q[r_rp];

endmodule
`default_nettype wire

// ===== src/gnz_fade.sv =====
// Three-stage fade curve 6t^5 - 15t^4 + 10t^3 in fixed point.
// Depends on gnz_pkg.
`default_nettype none
module gnz_fade (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [gnz_pkg::FRAC_BITS-1:0]  i_t,
    output logic [gnz_pkg::FADE_W-1:0]          o_fade
);
    import gnz_pkg::*;

    localparam logic [FADE_W-1:0] P15 = FADE_W'(15 * (2**FRAC_BITS));
    localparam logic [FADE_W-1:0] P10 = FADE_W'(10 * (2**FRAC_BITS));

    logic [FRAC_BITS-1:0]          r_t1;
    logic [FADE_W-1:0]             r_p;
    logic [FRAC_BITS-1:0]          r_c;
    logic [FADE_W-1:0]             r_q;
    logic [FRAC_BITS-1:0]          r_d;
    logic [FADE_W-1:0]             r_f;
    logic [2*FRAC_BITS-1:0]        tt;
    logic [FRAC_BITS+FADE_W-1:0]   tp;
    logic [2*FRAC_BITS-1:0]        ct;
    logic [FADE_W-1:0]             b;
    logic [FRAC_BITS+FADE_W-1:0]   db;

    assign tt = i_t * i_t;
    assign tp = r_t1 * r_p;
    assign ct = r_c * r_t1;
    assign b  = P10 - r_q;
    assign db = r_d * b;

    // A: p = 15 - 6t, c = t^2; B: q = t*p, d = c*t; C: d*(10 - q)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1 <= i_t;
            r_p  <= P15 - FADE_W'(i_t) * FADE_W'(6);
            r_c  <= tt[2*FRAC_BITS-1:FRAC_BITS];
            r_q  <= tp[FRAC_BITS +: FADE_W];
            r_d  <= ct[2*FRAC_BITS-1:FRAC_BITS];
            r_f  <= db[FRAC_BITS +: FADE_W];
        end
    end

    assign o_fade = r_f;

endmodule
`default_nettype wire

// ===== src/gnz_back.sv =====
// Back part: table lookups in three levels of replicated RAM copies,
// gradients, trilinear blend and saturation. Depends on gnz_pkg,
// gnz_ram and gnz_fade.
`default_nettype none
module gnz_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire gnz_pkg::t_qhead                i_head,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic signed [gnz_pkg::OUT_W-1:0]    o_noise_value
);
    import gnz_pkg::*;

    localparam logic [3:0] GH_ZX_A = 4'd12;
    localparam logic [3:0] GH_ZX_B = 4'd14;
    localparam logic signed [VAL_W-1:0] ONE_V  = VAL_W'(2**FRAC_BITS);
    localparam logic signed [VAL_W-1:0] NV_MAX = VAL_W'(2**(OUT_W-1) - 1);
    localparam logic signed [VAL_W-1:0] NV_MIN = VAL_W'(-(2**(OUT_W-1)));

    function automatic logic signed [VAL_W-1:0] grad(
        input logic [3:0] h,
        input logic signed [VAL_W-1:0] x,
        input logic signed [VAL_W-1:0] y,
        input logic signed [VAL_W-1:0] z
    );
        logic signed [VAL_W-1:0] u;
        logic signed [VAL_W-1:0] v;
        u = (h < 4'd8) ? x : y;
        if (h < 4'd4) begin
            v = y;
        end else if (h inside {GH_ZX_A, GH_ZX_B}) begin
            v = x;
        end else begin
            v = z;
        end
        if (h[0]) u = -u;
        if (h[1]) v = -v;
        return u + v;
    endfunction

    // a + floor(t * (b - a) / ONE)
    function automatic logic signed [VAL_W-1:0] lerp(
        input logic [FADE_W-1:0] t,
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0]          d;
        logic signed [VAL_W+FADE_W+1:0] p;
        d = {b[VAL_W-1], b} - {a[VAL_W-1], a};
        p = d * $signed({1'b0, t});
        return a + VAL_W'(p >>> FRAC_BITS);
    endfunction

    logic adv;

    // pipeline control and payload
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_ov;
    t_cmd r_c1, r_c2, r_c3;
    logic signed [VAL_W-1:0] r_g  [8];
    logic signed [VAL_W-1:0] r_l1 [4];
    logic signed [VAL_W-1:0] r_l2 [2];
    logic [FADE_W-1:0] r_u4, r_v4f, r_w4, r_v5f, r_w5, r_w6;
    logic signed [OUT_W-1:0] r_out;

    logic [FADE_W-1:0] fade [3];

    // RAM data
    logic [DATA_W-1:0] g1_rd_a, g1_rd_b;
    logic [DATA_W-1:0] g2a_rd_a, g2a_rd_b, g2b_rd_a, g2b_rd_b;
    logic [TAW-1:0]    a_idx, b_idx;
    logic [TAW-1:0]    g3_base [4];
    logic [DATA_W-1:0] g3_rd_a [4];
    logic [DATA_W-1:0] g3_rd_b [4];
    logic signed [VAL_W-1:0] off0 [3];
    logic signed [VAL_W-1:0] off1 [3];
    logic signed [VAL_W-1:0] g_n  [8];
    logic signed [VAL_W-1:0] l3_n;
    logic signed [OUT_W-1:0] sat_n;

    // whole pipeline moves unless the output register is full and stalled
    assign adv   = !r_ov || !i_out_stall;
    assign o_pop = adv;

    // fade units run alongside the lookups
    for (genvar i = 0; i < 3; i++) begin : g_fade
        gnz_fade u_fade (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_t    (i_head.cmd.frac[i]),
            .o_fade (fade[i])
        );
    end

    // level 1: perm[cx], perm[cx+1]; loads write this copy at the queue head
    gnz_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE)) u_ram_g1 (
        .i_clk     (i_clk),
        .i_we      (adv && i_head.valid && i_head.cmd.is_load),
        .i_waddr   (i_head.cmd.waddr),
        .i_wdata   (i_head.cmd.wdata),
        .i_re      (adv),
        .i_raddr_a (i_head.cmd.lattice[0]),
        .i_raddr_b (i_head.cmd.lattice[0] + TAW'(1)),
        .o_rdata_a (g1_rd_a),
        .o_rdata_b (g1_rd_b)
    );

    // level 2: a = perm[cx] + cy, b = perm[cx+1] + cy
    assign a_idx = g1_rd_a + r_c1.lattice[1];
    assign b_idx = g1_rd_b + r_c1.lattice[1];

    gnz_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE)) u_ram_g2a (
        .i_clk     (i_clk),
        .i_we      (adv && r_v1 && r_c1.is_load),
        .i_waddr   (r_c1.waddr),
        .i_wdata   (r_c1.wdata),
        .i_re      (adv),
        .i_raddr_a (a_idx),
        .i_raddr_b (a_idx + TAW'(1)),
        .o_rdata_a (g2a_rd_a),
        .o_rdata_b (g2a_rd_b)
    );

    gnz_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE)) u_ram_g2b (
        .i_clk     (i_clk),
        .i_we      (adv && r_v1 && r_c1.is_load),
        .i_waddr   (r_c1.waddr),
        .i_wdata   (r_c1.wdata),
        .i_re      (adv),
        .i_raddr_a (b_idx),
        .i_raddr_b (b_idx + TAW'(1)),
        .o_rdata_a (g2b_rd_a),
        .o_rdata_b (g2b_rd_b)
    );

    // level 3: corner hashes, copy k serves corner (x = k[0], y = k[1])
    assign g3_base[0] = g2a_rd_a + r_c2.lattice[2];  // aa
    assign g3_base[1] = g2b_rd_a + r_c2.lattice[2];  // ba
    assign g3_base[2] = g2a_rd_b + r_c2.lattice[2];  // ab
    assign g3_base[3] = g2b_rd_b + r_c2.lattice[2];  // bb

    for (genvar k = 0; k < 4; k++) begin : g_lvl3
        gnz_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_SIZE)) u_ram_g3 (
            .i_clk     (i_clk),
            .i_we      (adv && r_v2 && r_c2.is_load),
            .i_waddr   (r_c2.waddr),
            .i_wdata   (r_c2.wdata),
            .i_re      (adv),
            .i_raddr_a (g3_base[k]),
            .i_raddr_b (g3_base[k] + TAW'(1)),
            .o_rdata_a (g3_rd_a[k]),
            .o_rdata_b (g3_rd_b[k])
        );
    end

    // corner offsets and the eight gradients, index = z*4 + y*2 + x
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            off0[i] = VAL_W'({1'b0, r_c3.frac[i]});
            off1[i] = off0[i] - ONE_V;
        end
        for (int k = 0; k < 4; k++) begin
            g_n[k]     = grad(g3_rd_a[k][3:0], k[0] ? off1[0] : off0[0],
                              k[1] ? off1[1] : off0[1], off0[2]);
            g_n[k + 4] = grad(g3_rd_b[k][3:0], k[0] ? off1[0] : off0[0],
                              k[1] ? off1[1] : off0[1], off1[2]);
        end
    end

    // last blend along z and saturation
    always_comb begin
        l3_n = lerp(r_w6, r_l2[0], r_l2[1]);
        if (l3_n > NV_MAX) begin
            sat_n = NV_MAX[OUT_W-1:0];
        end else if (l3_n < NV_MIN) begin
            sat_n = NV_MIN[OUT_W-1:0];
        end else begin
            sat_n = l3_n[OUT_W-1:0];
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c1 <= i_head.cmd;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            r_g  <= g_n;
            r_u4 <= fade[0];
            r_v4f <= fade[1];
            r_w4 <= fade[2];
            for (int m = 0; m < 4; m++) begin
                r_l1[m] <= lerp(r_u4, r_g[2*m], r_g[2*m + 1]);
            end
            r_v5f <= r_v4f;
            r_w5 <= r_w4;
            for (int n = 0; n < 2; n++) begin
                r_l2[n] <= lerp(r_v5f, r_l1[2*n], r_l1[2*n + 1]);
            end
            r_w6 <= r_w5;
            r_out <= sat_n;
        end
    end

    // stage valids; loads leave after their last table write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_head.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && !r_c2.is_load;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_ov <= r_v6;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_noise_value = r_out;

endmodule
`default_nettype wire

// ===== src/gradient_noise_3d_core.sv =====
// Top level of the 3-D gradient noise core: front queue plus back pipeline.
// Depends on gnz_pkg, gnz_front and gnz_back.
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------
//  in      | i_in_valid / o_in_stall | i_kind, i_table_index, i_table_value,
//          |                         | i_x_coord, i_y_coord, i_z_coord
//  out     | o_out_valid / i_out_stall | o_noise_value (evaluate items only)
//
// One item per cycle sustained while the output is not stalled. An evaluate
// item passes through the queue and the first table read, two more chained
// table reads (each a registered RAM read on its own replicated copy), the
// gradients and three lerp levels into the output register. A load writes
// all seven table copies, one level per pipeline stage, in item order. Reset
// clears the queue and pipeline valids only; the table is undefined until
// loaded. An output stall freezes the pipeline.
`default_nettype none
module gradient_noise_3d_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_kind,
    input  wire logic [gnz_pkg::TAW-1:0]            i_table_index,
    input  wire logic [gnz_pkg::DATA_W-1:0]         i_table_value,
    input  wire logic signed [gnz_pkg::COORD_W-1:0] i_x_coord,
    input  wire logic signed [gnz_pkg::COORD_W-1:0] i_y_coord,
    input  wire logic signed [gnz_pkg::COORD_W-1:0] i_z_coord,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [gnz_pkg::OUT_W-1:0]        o_noise_value
);
    import gnz_pkg::*;

    t_qhead head;
    logic   pop;

    gnz_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_table_index (i_table_index),
        .i_table_value (i_table_value),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .i_z_coord     (i_z_coord),
        .o_head        (head),
        .i_pop         (pop)
    );

    gnz_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_noise_value (o_noise_value)
    );

endmodule
`default_nettype wire

// ===== src/gnz_checker.sv =====
// Port-level checks for gradient_noise_3d_core, bound to the top level.
// Depends on gnz_pkg.
`default_nettype none
module gnz_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_in_stall,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_stall,
    input wire logic signed [gnz_pkg::OUT_W-1:0]   o_noise_value
);
    import gnz_pkg::*;

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // reset empties the queue
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // a stalled result stays
    a_hold_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    // and keeps its value
    a_hold_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_noise_value))
        else $error("result changed under stall");

endmodule

bind gradient_noise_3d_core gnz_checker u_gnz_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_noise_value (o_noise_value)
);
`default_nettype wire
